@@ src/rdq_pkg.sv @@
`default_nettype none

package rdq_pkg;

    localparam int DEPTH      = 1024;
    localparam int VALUE_BITS = 16;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = PTR_W + 1;
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 2;
    localparam int OCC_W      = 11;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EMIT    = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ERROR    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic                  we;
        logic [PTR_W-1:0]      waddr;
        logic [VALUE_BITS-1:0] wdata;
        logic                  re;
        logic [PTR_W-1:0]      raddr;
    } t_mem_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              last;
        logic [OCC_W-1:0]  occupancy;
        logic              reversed;
    } t_op_res;

endpackage

`default_nettype wire

@@ src/rdq_ram.sv @@
`default_nettype none

module rdq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/rdq_ctrl.sv @@
`default_nettype none

module rdq_ctrl
    import rdq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_take,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [VALUE_BITS-1:0] i_value,
    output t_op_res                    o_res,
    output t_mem_req                   o_mem
);

    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_rev, n_rev;
    logic             r_err, n_err;

    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] back_sum;
    logic [PTR_W-1:0] tail_slot;
    logic [PTR_W-1:0] back_slot;
    logic [PTR_W-1:0] head_dec;
    logic [PTR_W-1:0] head_inc;
    logic             full;
    logic             empty;

    // Ring positions wrap with a single compare and subtract.
    always_comb begin
        tail_sum = {1'b0, r_head} + SUM_W'(r_count);
        back_sum = tail_sum - SUM_W'(1);
        tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                : PTR_W'(tail_sum);
        back_slot = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                : PTR_W'(back_sum);
        head_dec = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - PTR_W'(1);
        head_inc = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
        full     = (r_count == CNT_W'(DEPTH));
        empty    = (r_count == '0);
    end

    always_comb begin
        n_head = r_head;
        n_count = r_count;
        n_rev = r_rev;
        n_err = r_err;
        o_res.status = STAT_OK;
        o_res.last = 1'b0;
        o_mem.we = 1'b0;
        o_mem.waddr = tail_slot;
        o_mem.wdata = i_value;
        o_mem.re = 1'b0;
        o_mem.raddr = r_head;
        unique case (i_cmd) inside
            CMD_CLEAR: begin
                n_head = '0;
                n_count = '0;
                n_rev = 1'b0;
                n_err = 1'b0;
            end
            CMD_LOAD: begin
                if (full) begin
                    o_res.status = STAT_OVERFLOW;
                end else begin
                    o_mem.we = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (r_rev) begin
                        n_head = head_dec;
                        o_mem.waddr = head_dec;
                    end
                end
            end
            CMD_REVERSE: begin
                n_rev = ~r_rev;
            end
            CMD_DELETE, CMD_EMIT: begin
                if (r_err) begin
                    o_res.status = STAT_ERROR;
                end else if (empty) begin
                    if (i_cmd == CMD_DELETE) begin
                        n_err = 1'b1;
                        o_res.status = STAT_ERROR;
                    end else begin
                        o_res.status = STAT_EMPTY;
                    end
                end else begin
                    n_count = r_count - CNT_W'(1);
                    if (r_rev) begin
                        o_mem.raddr = back_slot;
                    end else begin
                        n_head = head_inc;
                    end
                    if (i_cmd == CMD_EMIT) begin
                        o_mem.re = 1'b1;
                        o_res.last = (r_count == CNT_W'(1));
                    end
                end
            end
            default: begin
            end
        endcase
        o_res.occupancy = OCC_W'(n_count);
        o_res.reversed = n_rev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_count <= '0;
            r_rev <= 1'b0;
            r_err <= 1'b0;
        end else if (i_take) begin
            r_head <= n_head;
            r_count <= n_count;
            r_rev <= n_rev;
            r_err <= n_err;
        end
    end

endmodule

`default_nettype wire

@@ src/reversible_deque.sv @@
`default_nettype none

// A bounded deque of DEPTH words held in one ring memory, with a direction flag that swaps
// which end counts as the front. Each accepted command returns exactly one result word.
// Clear, load, reverse and delete register their result directly; an emit that removes
// an element passes through a wait state, as the ring memory registers its read data. A new
// command is taken only when the output holds no result or its result is accepted in the
// same cycle, and never while an emit read is under way. There is no clearing pass after
// reset: entries are only ever read after a load has written them.
module reversible_deque
    import rdq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [VALUE_BITS-1:0] i_value,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [STAT_W-1:0]          o_status,
    output logic [VALUE_BITS-1:0]      o_out_value,
    output logic                       o_last,
    output logic [OCC_W-1:0]           o_occupancy,
    output logic                       o_reversed
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WAIT = 1'b1;

    logic                  r_state;
    logic                  r_valid;
    t_op_res               r_res;
    logic [VALUE_BITS-1:0] r_value;

    logic                  take;
    t_op_res               res;
    t_mem_req              mem;
    logic [VALUE_BITS-1:0] rdata;

    assign o_ready = (r_state == ST_IDLE) && (!r_valid || i_ready);
    assign take    = i_valid && o_ready;

    rdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_cmd   (i_cmd),
        .i_value (i_value),
        .o_res   (res),
        .o_mem   (mem)
    );

    rdq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (take && mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (take && mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else if (take) begin
            r_state <= mem.re ? ST_WAIT : ST_IDLE;
            r_valid <= ~mem.re;
        end else if (r_state == ST_WAIT) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b1;
        end else if (r_valid && i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= res;
            r_value <= '0;
        end else if (r_state == ST_WAIT) begin
            r_value <= rdata;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_res.status;
    assign o_out_value = r_value;
    assign o_last      = r_res.last;
    assign o_occupancy = r_res.occupancy;
    assign o_reversed  = r_res.reversed;

`ifndef SYNTHESIS
    a_wait_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WAIT |-> !r_valid)
        else $error("result shown while an emit read is outstanding");

    a_emit_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && mem.re |=> r_state == ST_WAIT && !o_ready)
        else $error("emit read not followed by the wait state");

    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_occupancy == '0)
        else $error("last word flagged with elements remaining");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_OVERFLOW |-> o_occupancy == OCC_W'(DEPTH))
        else $error("overflow reported on a deque that is not full");
`endif

endmodule

`default_nettype wire
